### design/gsim_pkg.sv
// shared constants, register codes and control types for the group-scaled int8 matvec
`timescale 1ns / 1ps

package gsim_pkg;

  localparam int LANES           = 4;
  localparam int MAX_GROUP       = 256;
  localparam int SCALE_FRAC_BITS = 20;

  localparam int DATA_W     = 8;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SCALE_W    = 24;
  localparam int PROD_MAX   = (1 << (DATA_W - 1)) * (1 << (DATA_W - 1));
  localparam int SUM_W      = $clog2(MAX_GROUP * PROD_MAX) + 2;
  localparam int GSIZE_W    = 9;
  localparam int VLEN_W     = 17;
  localparam int RCOUNT_W   = 17;
  localparam int ROW_IDX_W  = 16;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [GSIZE_W-1:0]  GRP_LEN_RST   = GSIZE_W'(64);
  localparam logic [VLEN_W-1:0]   VEC_LEN_RST   = VLEN_W'(4096);
  localparam logic [RCOUNT_W-1:0] ROW_COUNT_RST = RCOUNT_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRP_LEN   = 2'd0,
    REG_VEC_LEN   = 2'd1,
    REG_ROW_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic term;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic grp_close;
    logic row_close;
    logic row_hit;
  } status_t;

endpackage

### design/gsim_dp.sv
// datapath: config registers, lane products, group sum, scaling and saturating row accumulator
`timescale 1ns / 1ps

module gsim_dp #(
  parameter int SCALE_FRAC_BITS = gsim_pkg::SCALE_FRAC_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  input  logic [gsim_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [gsim_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [gsim_pkg::DATA_W-1:0]       act_in [gsim_pkg::LANES],
  input  logic signed [gsim_pkg::DATA_W-1:0]       wgt_in [gsim_pkg::LANES],
  input  logic [gsim_pkg::SCALE_W-1:0]             act_scale,
  input  logic [gsim_pkg::SCALE_W-1:0]             wgt_scale,
  input  gsim_pkg::cmd_t                           cmd,
  output gsim_pkg::status_t                        status,
  output logic signed [gsim_pkg::ACC_W-1:0]        row_value,
  output logic [gsim_pkg::ROW_IDX_W-1:0]           row_index,
  output logic                                     last_row,
  output logic                                     overflow
);

  localparam int SP_W = 2 * gsim_pkg::SCALE_W;
  localparam int PS_W = SP_W - SCALE_FRAC_BITS;
  localparam int GW   = gsim_pkg::GSIZE_W;
  localparam int VW   = gsim_pkg::VLEN_W;
  localparam int AW   = gsim_pkg::ACC_W;
  localparam int SW   = gsim_pkg::SUM_W;
  localparam int TP_W = SW + PS_W + 1;

  logic [GW-1:0]                       grp_len;
  logic [VW-1:0]                       vec_len;
  logic [gsim_pkg::RCOUNT_W-1:0]       row_count;

  logic signed [gsim_pkg::DATA_W-1:0]  act_q [gsim_pkg::LANES];
  logic signed [gsim_pkg::DATA_W-1:0]  wgt_q [gsim_pkg::LANES];
  logic [gsim_pkg::SCALE_W-1:0]        act_scale_q;
  logic [gsim_pkg::SCALE_W-1:0]        wgt_scale_q;

  logic signed [SW-1:0]                group_sum;
  logic [GW-1:0]                       group_elem_count;
  logic [VW-1:0]                       row_elem_count;
  logic [PS_W-1:0]                     scale_q;
  logic signed [AW-1:0]                term;
  logic signed [AW-1:0]                row_acc;
  logic                                row_overflow;
  logic [gsim_pkg::ROW_IDX_W-1:0]      row_counter;
  logic                                row_hit;

  logic [GW-1:0]                       gs_eff;
  logic signed [gsim_pkg::PROD_W-1:0]  lane_prod [gsim_pkg::LANES];
  logic signed [SW-1:0]                lane_sum;
  logic [GW-1:0]                       group_elem_count_next;
  logic [VW:0]                         row_elem_count_next;
  logic [SP_W-1:0]                     scale_prod;
  logic signed [TP_W-1:0]              term_prod;
  logic signed [AW-1:0]                acc_sum;
  logic                                acc_sat;
  logic                                last;

  always_comb begin
    if (grp_len < GW'(gsim_pkg::LANES)) begin
      gs_eff = GW'(gsim_pkg::LANES);
    end else if (grp_len > GW'(gsim_pkg::MAX_GROUP)) begin
      gs_eff = GW'(gsim_pkg::MAX_GROUP);
    end else begin
      gs_eff = grp_len;
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < gsim_pkg::LANES; k++) begin
      lane_prod[k] = act_q[k] * wgt_q[k];
      lane_sum     = lane_sum + SW'(lane_prod[k]);
    end
  end

  assign group_elem_count_next = group_elem_count + GW'(gsim_pkg::LANES);
  assign row_elem_count_next   = {1'b0, row_elem_count} + (VW + 1)'(gsim_pkg::LANES);
  assign scale_prod            = SP_W'(act_scale_q) * SP_W'(wgt_scale_q);
  assign term_prod             = group_sum * $signed({1'b0, scale_q});
  assign acc_sum               = row_acc + term;
  assign acc_sat               = (row_acc[AW-1] == term[AW-1]) && (acc_sum[AW-1] != row_acc[AW-1]);
  assign last                  = ({1'b0, row_counter} + gsim_pkg::RCOUNT_W'(1)) >= row_count;

  assign status.grp_close = group_elem_count_next >= gs_eff;
  assign status.row_close = row_elem_count_next >= {1'b0, vec_len};
  assign status.row_hit   = row_hit;

  // config and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_len          <= gsim_pkg::GRP_LEN_RST;
      vec_len          <= gsim_pkg::VEC_LEN_RST;
      row_count        <= gsim_pkg::ROW_COUNT_RST;
      group_sum        <= '0;
      group_elem_count <= '0;
      row_elem_count   <= '0;
      row_acc          <= '0;
      row_overflow     <= 1'b0;
      row_counter      <= '0;
      row_hit          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gsim_pkg::REG_GRP_LEN:   grp_len   <= cfg_data[GW-1:0];
          gsim_pkg::REG_VEC_LEN:   vec_len   <= cfg_data[VW-1:0];
          gsim_pkg::REG_ROW_COUNT: row_count <= cfg_data[gsim_pkg::RCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.sum) begin
        group_sum        <= group_sum + lane_sum;
        group_elem_count <= (status.grp_close || status.row_close) ? '0 : group_elem_count_next;
        row_elem_count   <= status.row_close ? '0 : row_elem_count_next[VW-1:0];
        row_hit          <= status.row_close;
      end
      if (cmd.term) begin
        group_sum <= '0;
      end
      if (cmd.acc) begin
        if (acc_sat) begin
          row_acc      <= row_acc[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
          row_overflow <= 1'b1;
        end else begin
          row_acc <= acc_sum;
        end
      end
      if (cmd.emit) begin
        row_acc      <= '0;
        row_overflow <= 1'b0;
        group_sum    <= '0;
        row_hit      <= 1'b0;
        row_counter  <= last ? '0 : row_counter + gsim_pkg::ROW_IDX_W'(1);
      end
    end
  end

  // item capture, scale product, group term and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q       <= act_in;
      wgt_q       <= wgt_in;
      act_scale_q <= act_scale;
      wgt_scale_q <= wgt_scale;
    end
    if (cmd.sum) begin
      scale_q <= scale_prod[SP_W-1:SCALE_FRAC_BITS];
    end
    if (cmd.term) begin
      term <= AW'(term_prod);
    end
    if (cmd.emit) begin
      row_value <= row_acc;
      row_index <= row_counter;
      last_row  <= last;
      overflow  <= row_overflow;
    end
  end

`ifndef SYNTH
  a_emit_clears_row: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (row_acc == '0) && !row_overflow && (group_sum == '0))
    else $error("row state not cleared after emit");

  a_term_clears_group: assert property (@(posedge clk) disable iff (rst)
    cmd.term |=> (group_sum == '0))
    else $error("group sum not cleared after group term");

  a_row_close_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.sum && status.row_close) |=> (row_elem_count == '0) && (group_elem_count == '0) && row_hit)
    else $error("element counts not reset at row end");
`endif

endmodule

### design/gsim_ctrl.sv
// controller: item sequencing state machine and output word valid
`timescale 1ns / 1ps

module gsim_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gsim_pkg::status_t status,
  output gsim_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_TERM = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (status.grp_close) begin
          state_next = ST_TERM;
        end else if (status.row_close) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TERM: begin
        cmd.term   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.row_hit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_accept_to_sum: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SUM))
    else $error("accepted word not followed by sum step");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("output word raised outside emit");

  a_emit_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_valid && !out_ready) |=> (state == ST_EMIT))
    else $error("emit left while output word still pending");
`endif

endmodule

### design/group_scaled_int8_matvec.sv
// top level: group-wise scaled int8 matrix-vector product, controller plus datapath
//
// Usage: configure the group length, vec_len and row_count on the cfg channel while the
// block is idle (index 0, 1, 2; other indexes are ignored, cfg_ready is always high). Then
// stream the matrix row by row on the input channel, one word of four act/wgt pairs at a
// time, each word carrying the group scales (only the word that closes a group uses them).
// One output word per row gives the saturated Q43.20 row value, its row index, the
// last-row flag and the row overflow flag.
// Sequencing: a word that does not close a group is accepted, then summed; one that
// closes a group adds the group term and accumulate steps; a word that ends a row adds
// the emit step that loads the output register. No new word is accepted until the last
// has passed these steps. The group scaling uses two registered multipliers (24x24
// scale product, then group sum times scale). The output word of a row-ending word is
// valid after its sum step, its term and accumulate steps if it closes a group, and emit.
// Reset: synchronous, clears all row state and loads the default configuration.
// Stall: the output register holds its word until taken; the next row-ending word waits
// in the emit step while the previous word is still pending, and no new word is accepted.
`timescale 1ns / 1ps

module group_scaled_int8_matvec #(
  parameter int SCALE_FRAC_BITS = gsim_pkg::SCALE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gsim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsim_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gsim_pkg::DATA_W-1:0]  act_0,
  input  logic signed [gsim_pkg::DATA_W-1:0]  act_1,
  input  logic signed [gsim_pkg::DATA_W-1:0]  act_2,
  input  logic signed [gsim_pkg::DATA_W-1:0]  act_3,
  input  logic signed [gsim_pkg::DATA_W-1:0]  wgt_0,
  input  logic signed [gsim_pkg::DATA_W-1:0]  wgt_1,
  input  logic signed [gsim_pkg::DATA_W-1:0]  wgt_2,
  input  logic signed [gsim_pkg::DATA_W-1:0]  wgt_3,
  input  logic [gsim_pkg::SCALE_W-1:0]        act_scale,
  input  logic [gsim_pkg::SCALE_W-1:0]        wgt_scale,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gsim_pkg::ACC_W-1:0]   row_value,
  output logic [gsim_pkg::ROW_IDX_W-1:0]      row_index,
  output logic                                last_row,
  output logic                                overflow
);

  logic signed [gsim_pkg::DATA_W-1:0] act_lane [gsim_pkg::LANES];
  logic signed [gsim_pkg::DATA_W-1:0] wgt_lane [gsim_pkg::LANES];
  gsim_pkg::cmd_t                     cmd;
  gsim_pkg::status_t                  status;

  assign cfg_ready = 1'b1;

  assign act_lane[0] = act_0;
  assign act_lane[1] = act_1;
  assign act_lane[2] = act_2;
  assign act_lane[3] = act_3;
  assign wgt_lane[0] = wgt_0;
  assign wgt_lane[1] = wgt_1;
  assign wgt_lane[2] = wgt_2;
  assign wgt_lane[3] = wgt_3;

  gsim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gsim_dp #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .act_in    (act_lane),
    .wgt_in    (wgt_lane),
    .act_scale (act_scale),
    .wgt_scale (wgt_scale),
    .cmd       (cmd),
    .status    (status),
    .row_value (row_value),
    .row_index (row_index),
    .last_row  (last_row),
    .overflow  (overflow)
  );

endmodule
